// ----- hw/rtl/ryiq_pkg.sv -----
// Shared constants, types and fixed-point helpers for the YIQ color correction pipeline.
// Used by rgb15_yiq_calibrated_to_rgb24, ryiq_isqrt and ryiq_div; depends on nothing.
package ryiq_pkg;

    // Fixed-point scale of every internal value.
    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;

    // Signed working width: holds values in -4.0 .. +4.0.
    localparam int MW   = FRAC_BITS + 3;
    // Width of a rounded product: holds values in -32.0 .. +32.0.
    localparam int PRW  = FRAC_BITS + 6;
    // Channel value 0 .. 1.0.
    localparam int CW   = FRAC_BITS + 1;
    // Chroma amplitude (square root) and its radicand.
    localparam int RW   = FRAC_BITS + 2;
    localparam int RADW = 2 * RW;
    // Chroma scaling divider: quotient and dividend magnitudes.
    localparam int QW   = FRAC_BITS + 2;
    localparam int DNW  = 2 * FRAC_BITS + 4;

    // Configuration data width and Q.14 rescaling shifts.
    localparam int REG_W = 16;
    localparam int SH_L  = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
    localparam int SH_R  = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;

    typedef logic signed [MW-1:0]  fx_t;
    typedef logic signed [PRW-1:0] wide_t;
    typedef logic [CW-1:0]         chan_t;
    typedef chan_t                 chan_table_t [32];

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_HUE_SINE,
        REG_HUE_COSINE,
        REG_GAIN,
        REG_EXCURSION
    } cfg_reg_t;

    // Round a constant given in thousandths to the internal scale, halves up.
    function automatic int kfx(input int milli);
        return (milli * ONE + 500) / 1000;
    endfunction

    localparam fx_t K_Y_R  = MW'(kfx(299));
    localparam fx_t K_Y_G  = MW'(kfx(587));
    localparam fx_t K_Y_B  = MW'(kfx(114));
    localparam fx_t K_U    = MW'(kfx(492));
    localparam fx_t K_V    = MW'(kfx(877));
    localparam fx_t K_R_I  = MW'(kfx(956));
    localparam fx_t K_R_Q  = MW'(kfx(620));
    localparam fx_t K_G_I  = MW'(kfx(272));
    localparam fx_t K_G_Q  = MW'(kfx(647));
    localparam fx_t K_B_I  = MW'(kfx(1108));
    localparam fx_t K_B_Q  = MW'(kfx(1705));
    localparam wide_t EPS_W = PRW'(kfx(1));
    localparam wide_t ONE_W = PRW'(ONE);

    // 5-bit channel code to 0 .. 1.0, rounded half up.
    function automatic chan_table_t build_chan_table();
        chan_table_t t;
        for (int n = 0; n < 32; n++)
        begin
            t[n] = CW'((n * ONE + 15) / 31);
        end
        return t;
    endfunction

    localparam chan_table_t CHAN_TABLE = build_chan_table();

    // Fixed-point product, rounded half up.
    function automatic wide_t fx_mul(input fx_t a, input fx_t b);
        logic signed [2*MW-1:0] p;
        p = a * b + (2*MW)'(ONE / 2);
        return PRW'(p >>> FRAC_BITS);
    endfunction

endpackage

// ----- hw/rtl/ryiq_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, one radicand per cycle.
// Depends on ryiq_pkg for RW and RADW.
module ryiq_isqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     valid_in,
    input  logic [ryiq_pkg::RADW-1:0] radicand,
    output logic                     valid_out,
    output logic [ryiq_pkg::RW-1:0]   root
);
    import ryiq_pkg::*;

    logic [RADW-1:0] rem_reg  [RW];
    logic [RADW-1:0] res_reg  [RW];
    logic            vld_reg  [RW];
    logic [RADW-1:0] rem_in   [RW];
    logic [RADW-1:0] res_in   [RW];
    logic [RADW-1:0] trial    [RW];
    logic [RADW-1:0] rem_next [RW];
    logic [RADW-1:0] res_next [RW];

    // One digit step per stage, testing bit 4^(RW-1-s).
    always_comb
    begin
        for (int s = 0; s < RW; s++)
        begin
            rem_in[s] = (s == 0) ? radicand : rem_reg[(s == 0) ? 0 : s - 1];
            res_in[s] = (s == 0) ? '0 : res_reg[(s == 0) ? 0 : s - 1];
            trial[s]  = res_in[s] + (RADW'(1) << (2 * (RW - 1 - s)));
            if (rem_in[s] >= trial[s])
            begin
                rem_next[s] = rem_in[s] - trial[s];
                res_next[s] = (res_in[s] >> 1) + (RADW'(1) << (2 * (RW - 1 - s)));
            end
            else
            begin
                rem_next[s] = rem_in[s];
                res_next[s] = res_in[s] >> 1;
            end
        end
    end

    // Valid bits follow the data down the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < RW; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= valid_in;
            for (int s = 1; s < RW; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Partial remainder and root of each stage.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < RW; s++)
        begin
            rem_reg[s] <= rem_next[s];
            res_reg[s] <= res_next[s];
        end
    end

    assign valid_out = vld_reg[RW-1];
    assign root      = res_reg[RW-1][RW-1:0];

endmodule

// ----- hw/rtl/ryiq_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage, one item per cycle.
// Depends on ryiq_pkg for DNW, RW and QW; the quotient must fit in QW bits.
module ryiq_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     valid_in,
    input  logic [ryiq_pkg::DNW-1:0] dividend,
    input  logic [ryiq_pkg::RW-1:0]  divisor,
    output logic                     valid_out,
    output logic [ryiq_pkg::QW-1:0]  quotient
);
    import ryiq_pkg::*;

    logic [DNW-1:0] rem_reg  [QW];
    logic [RW-1:0]  dsr_reg  [QW];
    logic [QW-1:0]  quo_reg  [QW];
    logic           vld_reg  [QW];
    logic [DNW-1:0] rem_in   [QW];
    logic [RW-1:0]  dsr_in   [QW];
    logic [QW-1:0]  quo_in   [QW];
    logic [DNW-1:0] shifted  [QW];
    logic [DNW-1:0] rem_next [QW];
    logic [QW-1:0]  quo_next [QW];

    // Stage s decides quotient bit QW-1-s.
    always_comb
    begin
        for (int s = 0; s < QW; s++)
        begin
            rem_in[s]  = (s == 0) ? dividend : rem_reg[(s == 0) ? 0 : s - 1];
            dsr_in[s]  = (s == 0) ? divisor : dsr_reg[(s == 0) ? 0 : s - 1];
            quo_in[s]  = (s == 0) ? '0 : quo_reg[(s == 0) ? 0 : s - 1];
            shifted[s] = DNW'(dsr_in[s]) << (QW - 1 - s);
            rem_next[s] = rem_in[s];
            quo_next[s] = quo_in[s];
            if (rem_in[s] >= shifted[s])
            begin
                rem_next[s] = rem_in[s] - shifted[s];
                quo_next[s][QW-1-s] = 1'b1;
            end
        end
    end

    // Valid bits follow the data down the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QW; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= valid_in;
            for (int s = 1; s < QW; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Remainder, divisor and partial quotient of each stage.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < QW; s++)
        begin
            rem_reg[s] <= rem_next[s];
            dsr_reg[s] <= dsr_in[s];
            quo_reg[s] <= quo_next[s];
        end
    end

    assign valid_out = vld_reg[QW-1];
    assign quotient  = quo_reg[QW-1];

endmodule

// ----- hw/rtl/rgb15_yiq_calibrated_to_rgb24.sv -----
// Top level of the YIQ color correction pipeline: 15-bit color in, 24-bit color out.
// Depends on ryiq_pkg, ryiq_isqrt and ryiq_div.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. busy is
//   always low: the pipeline takes one color in every cycle.
//   The corrected color appears on red_out, green_out and blue_out for one
//   cycle with done high. Items leave in the order they came in, one per cycle
//   at most.
//   The pipeline holds the chroma square root (one result bit per stage)
//   and the chroma scaling dividers (one quotient bit per stage), plus
//   thirteen stages of multiply, add and clamp logic around them.
//   The configuration port writes hue_sine, hue_cosine, brightness_gain and
//   max_excursion by index 0 .. 3; write only while no item is in flight
//   (not enforced by the block); stages using the registers read them directly.
//   The receiver cannot stall: done is a one-cycle strobe.
//   Reset empties the pipeline, drops items in flight and loads the
//   registers with their defaults (no hue rotation, unity gain, no
//   excursion).
module rgb15_yiq_calibrated_to_rgb24 (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [14:0]                color_in,
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [ryiq_pkg::REG_W-1:0] cfg_data,
    output logic                       done,
    output logic [7:0]                 red_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 blue_out
);
    import ryiq_pkg::*;

    localparam int LATENCY = 13 + RW + QW;

    // Configuration registers.
    logic [15:0] hue_sine_reg;
    logic [15:0] hue_cosine_reg;
    logic [14:0] gain_reg;
    logic [13:0] excursion_reg;

    fx_t   sn;
    fx_t   cs;
    fx_t   gain;
    wide_t ex_w;

    // Pipeline valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic v8_reg, v9_reg, v10_reg, v11_reg, v12_reg, done_reg;

    // Stage payloads.
    fx_t r1_reg, g1_reg, b1_reg;
    fx_t y2_reg, r2_reg, b2_reg;
    fx_t y3_reg, u3_reg, v3d_reg;
    fx_t p_cv4_reg, p_su4_reg, p_sv4_reg, p_cu4_reg, y4_reg;
    fx_t i5_reg, q5_reg, y5_reg;
    logic [RADW-1:0] ii6_reg, qq6_reg;
    fx_t i6_reg, q6_reg, y6_reg;
    logic [RADW-1:0] rad7_reg;
    fx_t i7_reg, q7_reg, y7_reg;
    fx_t sb_i_reg [RW];
    fx_t sb_q_reg [RW];
    fx_t sb_y_reg [RW];
    fx_t num8_reg, i8_reg, q8_reg, y8_reg;
    logic [RW-1:0] dsr8_reg;
    logic [DNW-1:0] pi9_reg, pq9_reg;
    logic si9_reg, sq9_reg;
    logic [RW-1:0] dsr9_reg;
    fx_t y9_reg;
    logic dsb_si_reg [QW];
    logic dsb_sq_reg [QW];
    fx_t  dsb_y_reg  [QW];
    fx_t i10_reg, q10_reg, y10_reg;
    wide_t p_ri11_reg, p_rq11_reg, p_gi11_reg, p_gq11_reg, p_bi11_reg, p_bq11_reg;
    fx_t y11_reg;
    wide_t r12_reg, g12_reg, b12_reg;
    logic [7:0] red_reg, green_reg, blue_reg;

    // Combinational intermediates.
    logic signed [2*MW-1:0] sq_i, sq_q;
    logic sq_valid;
    logic [RW-1:0] sq_root;
    wide_t c_w, y_w;
    logic too_high, too_low;
    fx_t num8_next;
    logic [RW-1:0] dsr8_next;
    fx_t i8_abs, n8_abs, q8_abs;
    logic [DNW-1:0] pi9_next, pq9_next;
    logic div_i_valid, div_q_valid;
    logic [QW-1:0] quo_i, quo_q;
    fx_t i10_mag, q10_mag;
    fx_t sb_i_abs;

    // Q.14 register value to the internal scale, rounded toward minus infinity.
    function automatic fx_t from_q14(input logic signed [31:0] v);
        return MW'((v <<< SH_L) >>> SH_R);
    endfunction

    // Clamp to 0 .. 1.0 and scale to 8 bits.
    function automatic logic [7:0] to_byte(input wide_t x);
        logic [FRAC_BITS:0]   cu;
        logic [FRAC_BITS+8:0] t;
        if (x < 0)
        begin
            cu = '0;
        end
        else if (x > ONE_W)
        begin
            cu = (FRAC_BITS + 1)'(ONE);
        end
        else
        begin
            cu = x[FRAC_BITS:0];
        end
        t = {cu, 8'b0} - (FRAC_BITS + 9)'(cu);
        return t[FRAC_BITS+7:FRAC_BITS];
    endfunction

    assign busy = 1'b0;

    // Configuration write decoder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_sine_reg   <= 16'h0000;
            hue_cosine_reg <= 16'h4000;
            gain_reg       <= 15'h4000;
            excursion_reg  <= 14'h0000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HUE_SINE:   hue_sine_reg   <= cfg_data;
                REG_HUE_COSINE: hue_cosine_reg <= cfg_data;
                REG_GAIN:       gain_reg       <= cfg_data[14:0];
                REG_EXCURSION:  excursion_reg  <= cfg_data[13:0];
                default:        hue_sine_reg   <= hue_sine_reg;
            endcase
        end
    end

    assign sn   = from_q14(32'(signed'(hue_sine_reg)));
    assign cs   = from_q14(32'(signed'(hue_cosine_reg)));
    assign gain = from_q14(signed'(32'(gain_reg)));
    assign ex_w = PRW'(from_q14(signed'(32'(excursion_reg))));

    // Squares for the chroma amplitude.
    assign sq_i = i5_reg * i5_reg;
    assign sq_q = q5_reg * q5_reg;

    ryiq_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v7_reg),
        .radicand  (rad7_reg),
        .valid_out (sq_valid),
        .root      (sq_root)
    );

    // Range check of luma against the chroma amplitude; pick the scale numerator.
    always_comb
    begin
        c_w      = PRW'(sq_root);
        y_w      = PRW'(sb_y_reg[RW-1]);
        too_high = (y_w + c_w) > (ONE_W + ex_w);
        too_low  = (y_w - c_w) < -ex_w;
        if (sq_root == '0)
        begin
            num8_next = '0;
            dsr8_next = RW'(1);
        end
        else
        begin
            dsr8_next = sq_root;
            if (too_high)
            begin
                num8_next = MW'(ONE_W + ex_w - EPS_W - y_w);
            end
            else if (too_low)
            begin
                num8_next = MW'(y_w + ex_w - EPS_W);
            end
            else
            begin
                num8_next = MW'(c_w);
            end
        end
    end

    // Magnitudes of the scaled chroma products.
    always_comb
    begin
        i8_abs   = i8_reg[MW-1] ? -i8_reg : i8_reg;
        q8_abs   = q8_reg[MW-1] ? -q8_reg : q8_reg;
        n8_abs   = num8_reg[MW-1] ? -num8_reg : num8_reg;
        pi9_next = i8_abs[MW-2:0] * n8_abs[MW-2:0];
        pq9_next = q8_abs[MW-2:0] * n8_abs[MW-2:0];
    end

    ryiq_div u_div_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v9_reg),
        .dividend  (pi9_reg),
        .divisor   (dsr9_reg),
        .valid_out (div_i_valid),
        .quotient  (quo_i)
    );

    ryiq_div u_div_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v9_reg),
        .dividend  (pq9_reg),
        .divisor   (dsr9_reg),
        .valid_out (div_q_valid),
        .quotient  (quo_q)
    );

    assign i10_mag = MW'(quo_i);
    assign q10_mag = MW'(quo_q);

    // Valid bits of the stages outside the square root and the dividers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            v11_reg  <= 1'b0;
            v12_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= sq_valid;
            v9_reg   <= v8_reg;
            v10_reg  <= div_i_valid && div_q_valid;
            v11_reg  <= v10_reg;
            v12_reg  <= v11_reg;
            done_reg <= v12_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        // Channel decode.
        r1_reg <= MW'(CHAN_TABLE[color_in[4:0]]);
        g1_reg <= MW'(CHAN_TABLE[color_in[9:5]]);
        b1_reg <= MW'(CHAN_TABLE[color_in[14:10]]);

        // Luma.
        y2_reg <= MW'(fx_mul(K_Y_R, r1_reg) + fx_mul(K_Y_G, g1_reg) + fx_mul(K_Y_B, b1_reg));
        r2_reg <= r1_reg;
        b2_reg <= b1_reg;

        // Color differences.
        u3_reg  <= MW'(fx_mul(K_U, b2_reg - y2_reg));
        v3d_reg <= MW'(fx_mul(K_V, r2_reg - y2_reg));
        y3_reg  <= y2_reg;

        // Hue rotation products and brightness.
        p_cv4_reg <= MW'(fx_mul(cs, v3d_reg));
        p_su4_reg <= MW'(fx_mul(sn, u3_reg));
        p_sv4_reg <= MW'(fx_mul(sn, v3d_reg));
        p_cu4_reg <= MW'(fx_mul(cs, u3_reg));
        y4_reg    <= MW'(fx_mul(y3_reg, gain));

        // I and Q.
        i5_reg <= p_cv4_reg - p_su4_reg;
        q5_reg <= p_sv4_reg + p_cu4_reg;
        y5_reg <= y4_reg;

        // Squares and radicand.
        ii6_reg  <= sq_i[RADW-1:0];
        qq6_reg  <= sq_q[RADW-1:0];
        i6_reg   <= i5_reg;
        q6_reg   <= q5_reg;
        y6_reg   <= y5_reg;
        rad7_reg <= ii6_reg + qq6_reg;
        i7_reg   <= i6_reg;
        q7_reg   <= q6_reg;
        y7_reg   <= y6_reg;

        // Side band alongside the square root.
        sb_i_reg[0] <= i7_reg;
        sb_q_reg[0] <= q7_reg;
        sb_y_reg[0] <= y7_reg;
        for (int s = 1; s < RW; s++)
        begin
            sb_i_reg[s] <= sb_i_reg[s-1];
            sb_q_reg[s] <= sb_q_reg[s-1];
            sb_y_reg[s] <= sb_y_reg[s-1];
        end

        // Scale numerator and divisor.
        num8_reg <= num8_next;
        dsr8_reg <= dsr8_next;
        i8_reg   <= sb_i_reg[RW-1];
        q8_reg   <= sb_q_reg[RW-1];
        y8_reg   <= sb_y_reg[RW-1];

        // Dividends and result signs.
        pi9_reg  <= pi9_next;
        pq9_reg  <= pq9_next;
        si9_reg  <= i8_reg[MW-1] ^ num8_reg[MW-1];
        sq9_reg  <= q8_reg[MW-1] ^ num8_reg[MW-1];
        dsr9_reg <= dsr8_reg;
        y9_reg   <= y8_reg;

        // Side band alongside the dividers.
        dsb_si_reg[0] <= si9_reg;
        dsb_sq_reg[0] <= sq9_reg;
        dsb_y_reg[0]  <= y9_reg;
        for (int s = 1; s < QW; s++)
        begin
            dsb_si_reg[s] <= dsb_si_reg[s-1];
            dsb_sq_reg[s] <= dsb_sq_reg[s-1];
            dsb_y_reg[s]  <= dsb_y_reg[s-1];
        end

        // Signed, scaled I and Q.
        i10_reg <= dsb_si_reg[QW-1] ? -i10_mag : i10_mag;
        q10_reg <= dsb_sq_reg[QW-1] ? -q10_mag : q10_mag;
        y10_reg <= dsb_y_reg[QW-1];

        // Back-conversion products.
        p_ri11_reg <= fx_mul(K_R_I, i10_reg);
        p_rq11_reg <= fx_mul(K_R_Q, q10_reg);
        p_gi11_reg <= fx_mul(K_G_I, i10_reg);
        p_gq11_reg <= fx_mul(K_G_Q, q10_reg);
        p_bi11_reg <= fx_mul(K_B_I, i10_reg);
        p_bq11_reg <= fx_mul(K_B_Q, q10_reg);
        y11_reg    <= y10_reg;

        // Channel sums.
        r12_reg <= PRW'(y11_reg) + p_ri11_reg + p_rq11_reg;
        g12_reg <= PRW'(y11_reg) - p_gi11_reg - p_gq11_reg;
        b12_reg <= PRW'(y11_reg) - p_bi11_reg + p_bq11_reg;

        // Clamp and truncate to 8 bits.
        red_reg   <= to_byte(r12_reg);
        green_reg <= to_byte(g12_reg);
        blue_reg  <= to_byte(b12_reg);
    end

    assign done      = done_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    // Magnitude of I leaving the square root, for the bound check below.
    assign sb_i_abs = sb_i_reg[RW-1][MW-1] ? -sb_i_reg[RW-1] : sb_i_reg[RW-1];

    // Every item taken comes out after the fixed latency.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item taken but no result after the pipeline latency");

    // Every result belongs to an item taken one latency earlier.
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    // Zero chroma amplitude only with I and Q both zero.
    a_zero_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_valid && sq_root == '0) |-> (sb_i_reg[RW-1] == '0 && sb_q_reg[RW-1] == '0))
        else $error("side band out of step with the square root");

    // The amplitude is never below |I|, so the quotient fits the divider.
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> (sb_i_abs[MW-2:0] <= sq_root))
        else $error("chroma amplitude below the magnitude of I");

endmodule

// ----- test/tb_rgb15_yiq_calibrated_to_rgb24.sv -----
// Self-checking testbench for rgb15_yiq_calibrated_to_rgb24: 15-bit colors in, 24-bit colors out.
// Predicts every color in fixed point and checks each done strobe in order.
// Depends on ryiq_pkg and the block's RTL only.
module tb_rgb15_yiq_calibrated_to_rgb24;
    timeunit 1ns;
    timeprecision 1ps;
    import ryiq_pkg::*;

    localparam int  FB       = FRAC_BITS;
    localparam longint UNIT  = longint'(1) << FB;
    localparam int  DRAIN    = 60;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb24_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [14:0] color_in;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [REG_W-1:0] cfg_data;
    logic        done;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;

    // Shadow copies of the configuration registers.
    logic [15:0] sine_reg;
    logic [15:0] cosine_reg;
    logic [14:0] gain_reg;
    logic [13:0] excursion_reg;

    rgb24_t expected_colors[$];
    int     mismatch_count;
    int     idle_pct;
    logic   busy_seen;

    rgb15_yiq_calibrated_to_rgb24 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .color_in  (color_in),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // busy as it stands just before the next rising edge.
    always @(negedge clk)
    begin
        busy_seen = busy;
    end

    function automatic longint kconst(input longint milli);
        return (milli * UNIT + 500) / 1000;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return (a * b + (UNIT >>> 1)) >>> FB;
    endfunction

    function automatic longint q14_scale(input longint v);
        return (v * UNIT) >>> 14;
    endfunction

    function automatic longint chroma_root(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = longint'(1) << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [7:0] clamp_byte(input longint x);
        if (x < 0)
            x = 0;
        if (x > UNIT)
            x = UNIT;
        return 8'((x * 255) >>> FB);
    endfunction

    // Full color correction path for one color under the current registers.
    function automatic rgb24_t correct_color(input logic [14:0] col);
        longint r, g, b, sn, cs, gain, ex, eps;
        longint y, u, v, ci, cq, c, num;
        rgb24_t res;
        r    = (longint'(col[4:0]) * UNIT + 15) / 31;
        g    = (longint'(col[9:5]) * UNIT + 15) / 31;
        b    = (longint'(col[14:10]) * UNIT + 15) / 31;
        sn   = q14_scale(longint'($signed(sine_reg)));
        cs   = q14_scale(longint'($signed(cosine_reg)));
        gain = q14_scale(longint'(gain_reg));
        ex   = q14_scale(longint'(excursion_reg));
        eps  = kconst(1);
        y  = fmul(kconst(299), r) + fmul(kconst(587), g) + fmul(kconst(114), b);
        u  = fmul(kconst(492), b - y);
        v  = fmul(kconst(877), r - y);
        ci = fmul(cs, v) - fmul(sn, u);
        cq = fmul(sn, v) + fmul(cs, u);
        y  = fmul(y, gain);
        c  = chroma_root(longint'(ci * ci) + longint'(cq * cq));
        // Pull chroma in when the composite swing leaves the allowed range.
        if (c != 0 && (y + c > UNIT + ex || y - c < -ex))
        begin
            if (y + c > UNIT + ex)
                num = UNIT + ex - eps - y;
            else
                num = y + ex - eps;
            ci = (ci * num) / c;
            cq = (cq * num) / c;
        end
        res.red   = clamp_byte(y + fmul(kconst(956), ci) + fmul(kconst(620), cq));
        res.green = clamp_byte(y - fmul(kconst(272), ci) - fmul(kconst(647), cq));
        res.blue  = clamp_byte(y - fmul(kconst(1108), ci) + fmul(kconst(1705), cq));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Check each color as the strobe marks it.
    always @(posedge clk)
    begin
        rgb24_t want;
        if (rst_n && done)
        begin
            if (expected_colors.size() == 0)
                report_mismatch("unexpected color", {red_out, green_out, blue_out}, 0);
            else
            begin
                want = expected_colors.pop_front();
                if (red_out != want.red)
                    report_mismatch("red_out", red_out, want.red);
                if (green_out != want.green)
                    report_mismatch("green_out", green_out, want.green);
                if (blue_out != want.blue)
                    report_mismatch("blue_out", blue_out, want.blue);
            end
        end
    end

    // Present one item, with random idle cycles ahead of it.
    task automatic send_color(input logic [14:0] col);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        color_in <= col;
        do
            @(posedge clk);
        while (busy_seen);
        expected_colors.push_back(correct_color(col));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_HUE_SINE:   sine_reg      = value;
            REG_HUE_COSINE: cosine_reg    = value;
            REG_GAIN:       gain_reg      = value[14:0];
            REG_EXCURSION:  excursion_reg = value[13:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [15:0] sn, input logic [15:0] cs,
                           input logic [15:0] gn, input logic [15:0] ex);
        write_reg(REG_HUE_SINE, sn);
        write_reg(REG_HUE_COSINE, cs);
        write_reg(REG_GAIN, gn);
        write_reg(REG_EXCURSION, ex);
    endtask

    // Primaries, secondaries, white, black, grays and other colors under default registers.
    task automatic test_default_colors();
        logic [14:0] colors [12] = '{15'h0000, 15'h7FFF, 15'h001F, 15'h03E0, 15'h7C00,
                                     15'h03FF, 15'h7C1F, 15'h7FE0, 15'h4210, 15'h0001,
                                     15'h0421, 15'h5555};
        foreach (colors[n])
            send_color(colors[n]);
    endtask

    // Chroma pulled in from above and below, negative scale, zero chroma.
    task automatic test_chroma_limits();
        set_all(16'h0000, 16'h4000, 16'h7FFF, 16'h0000);
        send_color(15'h7FFF);
        send_color(15'h03E0);
        send_color(15'h7FE0);
        set_all(16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_color(15'h7C00);
        send_color(15'h001F);
        send_color(15'h0000);
        set_all(16'h4000, 16'h0000, 16'h2000, 16'h3FFF);
        send_color(15'h7C00);
        send_color(15'h4210);
        // Sine and cosine beyond unity, both signs.
        set_all(16'h7FFF, 16'h8000, 16'h4000, 16'h0800);
        send_color(15'h001F);
        send_color(15'h7C1F);
    endtask

    // Random colors under random registers, with defaults in every sixth block, through the idle phases.
    task automatic test_random_colors();
        int pcts [4] = '{0, 56, 0, 15};
        for (int blk = 0; blk < 24; blk++)
        begin
            idle_pct = pcts[blk % 4];
            if (blk % 6 == 5)
                set_all(16'h0000, 16'h4000, 16'h4000, 16'h0000);
            else
                set_all($urandom_range(3) == 0 ? 16'($urandom) :
                            16'($signed($urandom_range(32768)) - 16384),
                        $urandom_range(3) == 0 ? 16'($urandom) :
                            16'($signed($urandom_range(32768)) - 16384),
                        16'($urandom), 16'($urandom));
            for (int n = 0; n < 70; n++)
            begin
                send_color(15'($urandom));
                // Hold off once until the pipeline has emptied.
                if (blk == 3 && n == 30)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        color_in = '0;
        cfg_write = 1'b0;
        cfg_index = REG_HUE_SINE;
        cfg_data = '0;
        busy_seen = 1'b0;
        mismatch_count = 0;
        idle_pct = 0;
        sine_reg = 16'h0000;
        cosine_reg = 16'h4000;
        gain_reg = 15'h4000;
        excursion_reg = 14'h0000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_colors();
        test_chroma_limits();
        test_random_colors();
        wait_drained();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop if the pipeline hangs.
    initial
    begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/ryiq_pkg.sv
hw/rtl/ryiq_isqrt.sv
hw/rtl/ryiq_div.sv
hw/rtl/rgb15_yiq_calibrated_to_rgb24.sv
test/tb_rgb15_yiq_calibrated_to_rgb24.sv
